// ===== rtl/ffba_pkg.sv =====
// Shared constants, codes and control types of the first-fit block allocator.
package ffba_pkg;

  localparam int MAX_BLOCKS    = 1024;
  localparam int BLOCK_SHIFT   = 12;
  localparam int AW            = $clog2(MAX_BLOCKS);
  localparam int CNT_W         = $clog2(MAX_BLOCKS + 1);
  localparam int NEED_W        = 33 - BLOCK_SHIFT;
  localparam int BLK_W         = 32 - BLOCK_SHIFT;
  localparam int ENTRY_W       = 3;
  localparam int ADDR_W        = 32;
  localparam int BIU_W         = 11;
  localparam int BLOCKS_RESET  = 1024;

  localparam int MARK_TAKEN    = 0;
  localparam int MARK_FIRST    = 1;
  localparam int MARK_NEXT     = 2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADADDR = 2'd2
  } status_t;

  typedef enum logic {
    REG_HEAP_BASE     = 1'b0,
    REG_BLOCKS_IN_USE = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MARK,
    S_FREE,
    S_RESP
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR_INIT,
    OP_CLEAR,
    OP_LOAD,
    OP_CHECK,
    OP_SCAN,
    OP_MARK,
    OP_FREE,
    OP_SEND
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_t;

  typedef struct packed {
    logic clear_done;
    logic check_fail;
    logic is_free;
    logic scan_found;
    logic scan_miss;
    logic mark_done;
    logic free_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/ffba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffba_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ffba_ctrl.sv =====
// Controller state machine of the first-fit block allocator.
module ffba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  ffba_pkg::sts_t sts,
  output ffba_pkg::ctl_t ctl
);

  import ffba_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE) && !cfg_we;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.check_fail) state_nxt = S_RESP;
        else if (sts.is_free) state_nxt = S_FREE;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_found) state_nxt = S_MARK;
        else if (sts.scan_miss) state_nxt = S_RESP;
      end
      S_MARK: begin
        if (sts.mark_done) state_nxt = S_RESP;
      end
      S_FREE: begin
        if (sts.free_done) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
    if (cfg_we) state_nxt = S_CLEAR;
  end

  always_comb begin
    ctl.op = OP_NONE;
    case (state_r)
      S_CLEAR: ctl.op = OP_CLEAR;
      S_IDLE: begin
        if (accept) ctl.op = OP_LOAD;
      end
      S_CHECK: ctl.op = OP_CHECK;
      S_SCAN:  ctl.op = OP_SCAN;
      S_MARK:  ctl.op = OP_MARK;
      S_FREE:  ctl.op = OP_FREE;
      S_RESP: begin
        if (sts.out_free) ctl.op = OP_SEND;
      end
      default: ctl.op = OP_NONE;
    endcase
    if (cfg_we) ctl.op = OP_CLR_INIT;
  end

endmodule

// ===== rtl/ffba_dp.sv =====
// Datapath of the first-fit block allocator: registers, block table and scan logic.
module ffba_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  ffba_pkg::ctl_t ctl,
  output ffba_pkg::sts_t sts,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [31:0]    cfg_wdata,
  input  logic [63:0]    in_tdata,
  input  logic [0:0]     in_tuser,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [31:0]    out_tdata,
  output logic [1:0]     out_tuser
);

  import ffba_pkg::*;

  logic [ADDR_W-1:0] base_r;
  logic [BIU_W-1:0]  biu_r;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic              dv_r, dv_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              func_r, func_nxt;
  logic [31:0]       size_r, size_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0]  didx_r, didx_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [CNT_W-1:0]  start_r, start_nxt;
  logic [CNT_W-1:0]  need_r, need_nxt;
  logic [CNT_W-1:0]  end_r, end_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [ADDR_W-1:0] out_data_r, out_data_nxt;
  status_t           out_user_r, out_user_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [CNT_W-1:0]  total;
  logic [NEED_W-1:0] need_w;
  logic              nomem;
  logic [ADDR_W-1:0] offs;
  logic [BLK_W-1:0]  blk;
  logic              bad;
  logic              taken;
  logic [CNT_W-1:0]  run_inc;
  logic [CNT_W-1:0]  start_sel;
  logic              found;
  logic              issue;
  logic              miss;
  logic              free_done;
  logic [ADDR_W-1:0] grant;
  logic [CNT_W-1:0]  ptr_inc;
  logic [ENTRY_W-1:0] mark_entry;

  ffba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign total   = (32'(biu_r) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(biu_r);
  assign need_w  = NEED_W'(size_r >> BLOCK_SHIFT) + NEED_W'(|size_r[BLOCK_SHIFT-1:0]);
  assign nomem   = (size_r == '0) || (32'(need_w) > 32'(total));
  assign offs    = addr_r - base_r;
  assign blk     = offs[ADDR_W-1:BLOCK_SHIFT];
  assign bad     = (addr_r == '0) || (addr_r < base_r) || (32'(blk) >= 32'(total));

  assign taken     = ram_rdata[MARK_TAKEN];
  assign run_inc   = run_r + CNT_W'(1);
  assign start_sel = (run_r == '0) ? didx_r : start_r;
  assign found     = dv_r && !taken && (run_inc == need_r);
  assign issue     = ptr_r < total;
  assign miss      = !dv_r && !issue;
  assign free_done = dv_r ? !ram_rdata[MARK_NEXT] : !issue;
  assign grant     = base_r + (ADDR_W'(start_sel) << BLOCK_SHIFT);
  assign ptr_inc   = ptr_r + CNT_W'(1);

  always_comb begin
    mark_entry             = '0;
    mark_entry[MARK_TAKEN] = 1'b1;
    mark_entry[MARK_FIRST] = (ptr_r == start_r);
    mark_entry[MARK_NEXT]  = (ptr_inc < end_r);
  end

  assign sts.clear_done = (ptr_r[AW-1:0] == AW'(MAX_BLOCKS - 1));
  assign sts.check_fail = func_r ? bad : nomem;
  assign sts.is_free    = func_r;
  assign sts.scan_found = found;
  assign sts.scan_miss  = miss && !found;
  assign sts.mark_done  = (ptr_inc == end_r);
  assign sts.free_done  = free_done;
  assign sts.out_free   = !out_valid_r || out_tready;

  always_comb begin
    ptr_nxt        = ptr_r;
    dv_nxt         = dv_r;
    func_nxt       = func_r;
    size_nxt       = size_r;
    addr_nxt       = addr_r;
    didx_nxt       = didx_r;
    run_nxt        = run_r;
    start_nxt      = start_r;
    need_nxt       = need_r;
    end_nxt        = end_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    ram_we         = 1'b0;
    ram_waddr      = ptr_r[AW-1:0];
    ram_wdata      = '0;
    case (ctl.op)
      OP_CLR_INIT: begin
        ptr_nxt = '0;
      end
      OP_CLEAR: begin
        ram_we  = 1'b1;
        ptr_nxt = ptr_inc;
      end
      OP_LOAD: begin
        func_nxt = in_tuser[0];
        size_nxt = in_tdata[31:0];
        addr_nxt = in_tdata[63:32];
      end
      OP_CHECK: begin
        ptr_nxt        = func_r ? CNT_W'(blk) : '0;
        dv_nxt         = 1'b0;
        run_nxt        = '0;
        need_nxt       = CNT_W'(need_w);
        res_addr_nxt   = '0;
        if (func_r) res_status_nxt = bad ? ST_BADADDR : ST_OK;
        else res_status_nxt = nomem ? ST_NOMEM : ST_OK;
      end
      OP_SCAN: begin
        if (issue) ptr_nxt = ptr_inc;
        dv_nxt   = issue;
        didx_nxt = ptr_r;
        if (dv_r) begin
          if (taken) begin
            run_nxt = '0;
          end else begin
            run_nxt   = run_inc;
            start_nxt = start_sel;
          end
        end
        if (found) begin
          ptr_nxt      = start_sel;
          end_nxt      = start_sel + need_r;
          res_addr_nxt = grant;
        end else if (miss) begin
          res_status_nxt = ST_NOMEM;
        end
      end
      OP_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = mark_entry;
        ptr_nxt   = ptr_inc;
      end
      OP_FREE: begin
        if (issue) ptr_nxt = ptr_inc;
        dv_nxt   = issue;
        didx_nxt = ptr_r;
        if (dv_r) begin
          ram_we    = 1'b1;
          ram_waddr = didx_r[AW-1:0];
        end
      end
      OP_SEND: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_addr_r;
        out_user_nxt  = res_status_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      biu_r       <= BIU_W'(BLOCKS_RESET);
      ptr_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_HEAP_BASE:     base_r <= cfg_wdata;
          REG_BLOCKS_IN_USE: biu_r  <= cfg_wdata[BIU_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    size_r       <= size_nxt;
    addr_r       <= addr_nxt;
    didx_r       <= didx_nxt;
    run_r        <= run_nxt;
    start_r      <= start_nxt;
    need_r       <= need_nxt;
    end_r        <= end_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== rtl/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator: controller, datapath and table.
//
// Keeps one 3-bit entry per 4 KiB heap block in a single-port-read table RAM and
// serves one request at a time. An allocate word scans table entries up to the end
// of the first fitting run and then marks each block of that run; an allocate word
// that finds no run scans every managed block; a free word walks the blocks on its
// continue chain; requests rejected up front touch no table entry. The table is
// walked through its single read port, one entry per cycle. After reset and after
// every configuration write the table is cleared in one pass, during which no
// request word is taken. A finished result waits in the output register while the
// next request word is accepted.
module first_fit_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // size_bytes[31:0], free_address[63:32]
  input  logic [0:0]  in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // granted_address[31:0]
  output logic [1:0]  out_tuser   // status[1:0]
);

  import ffba_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  ffba_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
